### rtl/core/pmsr_pkg.sv
// Package for the shuffled Lehmer generator core: field widths, generator constants,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package pmsr_pkg;

    localparam int VALUE_W         = 31;
    localparam int FRAC_W          = 24;
    localparam int MULT_W          = 15;
    localparam int PROD_W          = VALUE_W + MULT_W;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int WARMUP_STEPS    = 8;

    localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
    localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [FRAC_W-1:0]  FRAC_MAX = 24'd16777214;

    // Slot estimate: floor(value * RECIP / 2^RECIP_SHIFT), off by at most one
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_LOAD,
        ST_SEED_MUL,
        ST_SEED_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED,
        ST_DRAW_MEM,
        ST_DRAW_OUT
    } t_ctrl_state;

    typedef struct packed {
        logic load_seed;
        logic step_mul;
        logic seed_red;
        logic draw_red;
        logic tbl_swap;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic seeded;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/pmsr_if.sv
// Valid/ready channel interfaces for the request and response beats of the core.
// Depends on pmsr_pkg for field widths.
interface pmsr_req_if import pmsr_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface pmsr_rsp_if import pmsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [FRAC_W-1:0]  fraction;

    modport source (output valid, output value, output fraction, input ready);
    modport sink   (input valid, input value, input fraction, output ready);
endinterface

### rtl/core/pmsr_ctrl.sv
// Controller state machine: sequences seeding steps and the draw of one deviate.
// Depends on pmsr_pkg for the state type and command/status structs.
module pmsr_ctrl import pmsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_restart,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_in_restart || !i_status.seeded) ? ST_SEED_LOAD : ST_DRAW_MUL;
                end
            end
            ST_SEED_LOAD: begin
                o_cmd.load_seed = 1'b1;
                n_state         = ST_SEED_MUL;
            end
            ST_SEED_MUL: begin
                o_cmd.step_mul = 1'b1;
                n_state        = ST_SEED_RED;
            end
            ST_SEED_RED: begin
                o_cmd.seed_red = 1'b1;
                n_state        = i_status.cnt_zero ? ST_DRAW_MUL : ST_SEED_MUL;
            end
            ST_DRAW_MUL: begin
                o_cmd.step_mul = 1'b1;
                n_state        = ST_DRAW_RED;
            end
            ST_DRAW_RED: begin
                o_cmd.draw_red = 1'b1;
                n_state        = ST_DRAW_MEM;
            end
            ST_DRAW_MEM: begin
                o_cmd.tbl_swap = 1'b1;
                n_state        = ST_DRAW_OUT;
            end
            ST_DRAW_OUT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### rtl/core/pmsr_dpath.sv
// Datapath: seed register, Lehmer multiply and Mersenne reduction, slot divider,
// shuffle table memory and output register with the Q0.24 fraction.
// Depends on pmsr_pkg for constants and command/status structs.
module pmsr_dpath import pmsr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [VALUE_W-1:0] i_cfg_wdata,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [VALUE_W-1:0] o_out_value,
    output logic [FRAC_W-1:0]  o_out_fraction
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int QW       = AW + 1;
    localparam int CW       = $clog2(TABLE_DEPTH + WARMUP_STEPS);
    localparam int QP_W     = VALUE_W + RECIP_W;
    localparam int QM_W     = VALUE_W + QW;
    localparam longint SlotDivL  = 1 + (longint'(LCG_MOD) - 1) / TABLE_DEPTH;
    localparam longint SlotRecip = (longint'(1) <<< RECIP_SHIFT) / SlotDivL;
    localparam logic [VALUE_W-1:0] SLOT_DIV   = VALUE_W'(SlotDivL);
    localparam logic [RECIP_W-1:0] SLOT_RECIP = RECIP_W'(SlotRecip);

    logic [VALUE_W-1:0] r_seed;
    logic [VALUE_W-1:0] r_state;
    logic [VALUE_W-1:0] r_last;
    logic [PROD_W-1:0]  r_prod;
    logic [QW-1:0]      r_qest;
    logic [AW-1:0]      r_slot;
    logic [CW-1:0]      r_cnt;
    logic [VALUE_W-1:0] r_rdata;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [FRAC_W-1:0]  r_out_frac;
    logic [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic [VALUE_W-1:0] seed_start;
    logic [VALUE_W:0]   red_sum;
    logic [VALUE_W-1:0] red_val;
    logic [QP_W-1:0]    qest_prod;
    logic [QM_W-1:0]    q_mul;
    logic [VALUE_W-1:0] q_rem;
    logic [QW-1:0]      q_fix;
    logic [AW-1:0]      slot_cap;
    logic               fill_en;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [VALUE_W:0]   frac_rem;
    logic [FRAC_W:0]    frac_q;
    logic [FRAC_W-1:0]  frac_val;

    // zero and the modulus itself both start the generator at one
    assign seed_start = (r_seed == '0 || r_seed == LCG_MOD) ? VALUE_W'(1) : r_seed;

    // 2^31 = 1 mod M: fold the high part onto the low part, subtract once
    always_comb begin
        red_sum = {1'b0, r_prod[VALUE_W-1:0]} + (VALUE_W + 1)'(r_prod[PROD_W-1:VALUE_W]);
        red_val = (red_sum >= {1'b0, LCG_MOD}) ? VALUE_W'(red_sum - {1'b0, LCG_MOD})
                                               : red_sum[VALUE_W-1:0];
    end

    // slot = last / SLOT_DIV: reciprocal estimate, then one correction, then cap
    assign qest_prod = QP_W'(r_last) * QP_W'(SLOT_RECIP);

    always_comb begin
        q_mul = QM_W'(r_qest) * QM_W'(SLOT_DIV);
        q_rem = r_last - q_mul[VALUE_W-1:0];
        q_fix = r_qest + QW'(q_rem >= SLOT_DIV);
        if (q_fix > QW'(TABLE_DEPTH - 1)) begin
            slot_cap = AW'(TABLE_DEPTH - 1);
        end else begin
            slot_cap = q_fix[AW-1:0];
        end
    end

    // fraction = floor(v * 2^24 / M); x = q0*M + (lo + q0) with q0 = x >> 31
    always_comb begin
        frac_rem = {1'b0, r_rdata[6:0], 24'b0} + (VALUE_W + 1)'(r_rdata[VALUE_W-1:7]);
        frac_q   = {1'b0, r_rdata[VALUE_W-1:7]} + (FRAC_W + 1)'(frac_rem >= {1'b0, LCG_MOD});
        frac_val = (frac_q > {1'b0, FRAC_MAX}) ? FRAC_MAX : frac_q[FRAC_W-1:0];
    end

    assign fill_en = i_cmd.seed_red && (r_cnt < CW'(TABLE_DEPTH));
    assign wr_en   = fill_en || i_cmd.tbl_swap;
    assign wr_addr = i_cmd.tbl_swap ? r_slot : r_cnt[AW-1:0];
    assign wr_data = i_cmd.tbl_swap ? r_state : red_val;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.tbl_swap) begin
            r_rdata <= mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= VALUE_W'(1);
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.seed_red && r_cnt == '0) begin
                r_last <= red_val;
            end else if (i_cmd.out_load) begin
                r_last <= r_rdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_state <= seed_start;
            r_cnt   <= CW'(TABLE_DEPTH + WARMUP_STEPS - 1);
        end
        if (i_cmd.step_mul) begin
            r_prod <= PROD_W'(r_state) * PROD_W'(LCG_MULT);
            r_qest <= qest_prod[RECIP_SHIFT+QW-1:RECIP_SHIFT];
        end
        if (i_cmd.seed_red) begin
            r_state <= red_val;
            r_cnt   <= r_cnt - CW'(1);
        end
        if (i_cmd.draw_red) begin
            r_state <= red_val;
            r_slot  <= slot_cap;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_rdata;
            r_out_frac  <= frac_val;
        end
    end

    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_status.seeded   = (r_last != '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_out_value    = r_out_value;
    assign o_out_fraction = r_out_frac;

endmodule

### rtl/core/park_miller_shuffled_rng_core.sv
// Top level of the shuffled minimal-standard Lehmer generator core.
// Depends on pmsr_pkg, pmsr_if, pmsr_ctrl and pmsr_dpath.
//
//  channel   dir   handshake              payload
//  i_req     in    valid / ready          restart (1)
//  o_rsp     out   valid / ready          value (31), fraction (24)
//  i_cfg     in    i_cfg_we, no wait      i_cfg_wdata (31) -> seed
//
// A draw runs from the accepting edge to the result beat through one Lehmer
// step (multiply, then Mersenne fold) overlapped with the slot divide, the
// swap on the single table port, then the load of the output register.
// A beat that seeds first (restart, or first beat after reset) adds a seed
// load and then TABLE_DEPTH + 8 generator steps, each passing through the
// multiplier in a multiply state and then a reduce state.
// Reset (i_rst_n low, synchronous) sets seed to 1 and marks the core unseeded.
// One beat is in work at a time; i_req.ready is high while the core is idle,
// even while a result still waits in the output register. A stalled o_rsp
// holds the core in its last draw cycle until the output register drains.
module park_miller_shuffled_rng_core import pmsr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [VALUE_W-1:0] i_cfg_wdata,
    pmsr_req_if.sink           i_req,
    pmsr_rsp_if.source         o_rsp
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequence seeding and draws
    pmsr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_in_restart (i_req.restart),
        .o_in_ready   (i_req.ready),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd)
    );

    // generator, shuffle table and output register
    pmsr_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_out_value    (o_rsp.value),
        .o_out_fraction (o_rsp.fraction)
    );

endmodule

### rtl/core/pmsr_checker.sv
// Port-level checker for park_miller_shuffled_rng_core, attached by a bind.
// Depends on pmsr_pkg for widths and constants.
module pmsr_checker import pmsr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [VALUE_W-1:0] i_out_value,
    input logic [FRAC_W-1:0]  i_out_fraction
);

    // no result beat right after reset
    a_rst_no_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_fraction))
        else $error("stalled result changed");

    // one beat in work: ready drops after an accepted request
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    // value stays inside 1 .. M-1
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_value != '0) && (i_out_value != LCG_MOD))
        else $error("value out of range");

    // fraction stays below one and never exceeds the value's top bits plus one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_fraction <= FRAC_MAX)
            && ((FRAC_W + 1)'(i_out_fraction)
                <= (FRAC_W + 1)'(i_out_value[VALUE_W-1:7]) + (FRAC_W + 1)'(1)))
        else $error("fraction out of range");

endmodule

bind park_miller_shuffled_rng_core pmsr_checker u_pmsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_value    (o_rsp.value),
    .i_out_fraction (o_rsp.fraction)
);

### bench/tb.sv
// Self-checking bench for park_miller_shuffled_rng_core: a scoreboard class predicts every
// deviate; tasks drive request beats and seed writes, a process drives rsp back-pressure.
// Depends on pmsr_pkg, pmsr_if and the core RTL.
`timescale 1ns / 100ps

import pmsr_pkg::*;

typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [FRAC_W-1:0]  fraction;
} t_rng_draw;

class rng_scoreboard;
    localparam longint unsigned MOD_L    = LCG_MOD;
    localparam longint unsigned MULT_L   = LCG_MULT;
    localparam longint unsigned SLOT_DIV = 1 + (MOD_L - 1) / TABLE_DEPTH_DEF;

    logic [VALUE_W-1:0] seed_reg;
    logic [VALUE_W-1:0] lehmer;
    logic [VALUE_W-1:0] last_value;
    logic [VALUE_W-1:0] shuffle [TABLE_DEPTH_DEF];
    t_rng_draw          expected_draws [$];
    int                 errors;

    function new();
        seed_reg   = 1;
        lehmer     = '0;
        last_value = '0;
        errors     = 0;
        foreach (shuffle[i]) shuffle[i] = '0;
    endfunction

    function logic [VALUE_W-1:0] lehmer_advance(input logic [VALUE_W-1:0] s);
        longint unsigned p;
        p = longint'(s) * MULT_L;
        return VALUE_W'(p % MOD_L);
    endfunction

    // Warm up, then fill the table from the top slot down.
    function void reseed();
        logic [VALUE_W-1:0] s;
        s = seed_reg;
        if (s == 0 || s == LCG_MOD) s = 1;
        for (int i = TABLE_DEPTH_DEF + WARMUP_STEPS - 1; i >= 0; i--) begin
            s = lehmer_advance(s);
            if (i < TABLE_DEPTH_DEF) shuffle[i] = s;
        end
        lehmer     = s;
        last_value = shuffle[0];
    endfunction

    function void note_seed(input logic [VALUE_W-1:0] v);
        seed_reg = v;
    endfunction

    function void note_request(input bit restart);
        longint unsigned slot;
        longint unsigned frac;
        t_rng_draw       d;
        if (restart || last_value == 0) reseed();
        lehmer = lehmer_advance(lehmer);
        slot   = longint'(last_value) / SLOT_DIV;
        if (slot >= TABLE_DEPTH_DEF) slot = TABLE_DEPTH_DEF - 1;
        last_value    = shuffle[slot];
        shuffle[slot] = lehmer;
        frac = (longint'(last_value) << FRAC_W) / MOD_L;
        if (frac > longint'(FRAC_MAX)) frac = longint'(FRAC_MAX);
        d.value    = last_value;
        d.fraction = frac[FRAC_W-1:0];
        expected_draws.push_back(d);
    endfunction

    function void check_draw(input logic [VALUE_W-1:0] value,
                             input logic [FRAC_W-1:0] fraction);
        t_rng_draw d;
        if (expected_draws.size() == 0) begin
            $display("%0t: unexpected response beat, value %h fraction %h",
                     $time, value, fraction);
            errors++;
            return;
        end
        d = expected_draws.pop_front();
        if (value !== d.value) begin
            $display("%0t: value mismatch, expected %h actual %h", $time, d.value, value);
            errors++;
        end
        if (fraction !== d.fraction) begin
            $display("%0t: fraction mismatch, expected %h actual %h",
                     $time, d.fraction, fraction);
            errors++;
        end
    endfunction

    function int pending();
        return expected_draws.size();
    endfunction
endclass

module tb;
    localparam int CLK_PERIOD     = 8;
    localparam int RANDOM_ITEMS   = 900;
    localparam int RX_HOLD_CYCLES = 400;
    // Worst quiet stretch: hold-off plus a seeding draw plus a long gap, taken several times
    localparam int STALL_LIMIT    = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [VALUE_W-1:0] i_cfg_wdata;

    pmsr_req_if req_ch ();
    pmsr_rsp_if rsp_ch ();

    park_miller_shuffled_rng_core #(
        .TABLE_DEPTH (TABLE_DEPTH_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    rng_scoreboard sb;

    // Idle-pattern controls, changed per phase by the main sequence
    bit tx_steady;
    bit rx_steady;
    bit rx_hold_req;
    int quiet_cycles;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Favor the edges of the seed range: zero, one, the top legal value and the modulus.
    function automatic logic [VALUE_W-1:0] pick_seed();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return 31'd1;
            2: return LCG_MOD - 31'd1;
            3: return LCG_MOD;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Response side: sample every beat at the rising edge, and count edges with
    // no beat on either channel so a hung core ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_draw(rsp_ch.value, rsp_ch.fraction);
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Receiver back-pressure. A hold request drops ready for a long stretch so the
    // core fills its output register, accepts one more request and then stalls.
    initial begin
        int gap;
        gap = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rsp_ch.ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            if (gap > 0) begin
                rsp_ch.ready = 1'b0;
                gap--;
            end else begin
                rsp_ch.ready = 1'b1;
                if (!rx_steady) gap = idle_len();
            end
        end
    end

    // Offer one request beat, after an optional gap, and hold it until accepted.
    // Entered and left at a falling edge; valid stays high into the next beat.
    task automatic send_request(input bit restart);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.restart = restart;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(restart);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted deviate has come back.
    task automatic drain();
        req_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the seed register; only done while the core is idle.
    task automatic write_seed(input logic [VALUE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.note_seed(v);
    endtask

    initial begin
        int sent;
        int phase;
        int len;

        sb             = new();
        quiet_cycles   = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rx_hold_req    = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Not seeded after reset: the first beat seeds from the reset seed even
        // without restart. Run back to back first, then with gaps.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Zero seed is taken as one
        write_seed('0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // Seed equal to the modulus folds to zero, so also taken as one
        write_seed(LCG_MOD);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // Top legal seed
        write_seed(LCG_MOD - 31'd1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // A seed write alone leaves the running sequence alone until restart
        write_seed(VALUE_W'($urandom));
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // Random phases: mostly a fresh seed and a restart followed by a run of
        // plain draws, with a stray restart now and then.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            len       = $urandom_range(20, 80);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) write_seed(pick_seed());
            if (phase == 2 || phase == 7) rx_hold_req = 1'b1;
            for (int k = 0; k < len; k++) begin
                if (k == 0) send_request($urandom_range(0, 3) != 0);
                else        send_request($urandom_range(0, 29) == 0);
            end
            sent += len;
            phase++;
            drain();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
